FILE: design/assert_macros.svh
// Assertion macros for the design files that check their own logic.
// Each check is clocked on the given edge and is switched off while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TMM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tmm: assertion failed");
`define TMM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tmm: assertion failed");
`else
`define TMM_ASSERT(label, clk, rst_n, prop)
`define TMM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/tmm_pkg.sv
package tmm_pkg;

  localparam int MaxDim     = 8;
  localparam int StoreDepth = MaxDim * MaxDim;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int DimW       = 4;
  localparam int PosW       = 3;
  localparam int ElemW      = 16;
  localparam int MulW       = 2 * ElemW;
  localparam int ProdW      = 36;
  localparam int RegIdxW    = 3;
  localparam int PaddrW     = RegIdxW + 2;

  // Register indexes on the configuration port.
  localparam logic [RegIdxW-1:0] RegARows = 3'd0;
  localparam logic [RegIdxW-1:0] RegACols = 3'd1;
  localparam logic [RegIdxW-1:0] RegBRows = 3'd2;
  localparam logic [RegIdxW-1:0] RegBCols = 3'd3;
  localparam logic [RegIdxW-1:0] RegFlipA = 3'd4;
  localparam logic [RegIdxW-1:0] RegFlipB = 3'd5;

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_RUN    = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_LOAD_A   = 2'd0,
    KIND_LOAD_B   = 2'd1,
    KIND_RUN      = 2'd2,
    KIND_MISMATCH = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]              operation;
    logic [AddrW-1:0]        index;
    logic signed [ElemW-1:0] element;
  } in_word_t;

  typedef struct packed {
    logic signed [ProdW-1:0] product;
    logic [PosW-1:0]         row;
    logic [PosW-1:0]         col;
    logic                    last;
    logic                    status;
  } out_word_t;

  typedef struct packed {
    logic [DimW-1:0] a_rows;
    logic [DimW-1:0] a_cols;
    logic [DimW-1:0] b_rows;
    logic [DimW-1:0] b_cols;
    logic            flip_a;
    logic            flip_b;
  } cfg_t;

  // Shape of one product run, fixed when the compute word is classified.
  typedef struct packed {
    logic [DimW-1:0] out_rows;
    logic [DimW-1:0] out_cols;
    logic [DimW-1:0] inner;
    logic [DimW-1:0] a_cols;
    logic [DimW-1:0] b_cols;
    logic            flip_a;
    logic            flip_b;
  } geom_t;

  typedef struct packed {
    kind_e                   kind;
    logic [AddrW-1:0]        index;
    logic signed [ElemW-1:0] element;
    geom_t                   geom;
  } job_t;

endpackage

FILE: design/tmm_front.sv
module tmm_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  tmm_pkg::in_word_t            in_word_i,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tmm_pkg::PaddrW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output tmm_pkg::cfg_t                cfg_o,
  output tmm_pkg::job_t                job_o,
  output logic                         job_valid_o,
  input  logic                         job_pop_i
);
  import tmm_pkg::*;

  cfg_t                 cfg_q;
  job_t                 fifo_q [2];
  logic                 wr_ptr_q, rd_ptr_q;
  logic [1:0]           count_q;
  job_t                 job_d;
  logic                 push, pop;
  logic                 cfg_we;
  logic [RegIdxW-1:0]   reg_idx;
  logic                 dims_ok;
  logic [DimW-1:0]      inner_b;

  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = paddr[PaddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.a_rows <= DimW'(1);
      cfg_q.a_cols <= DimW'(1);
      cfg_q.b_rows <= DimW'(1);
      cfg_q.b_cols <= DimW'(1);
      cfg_q.flip_a <= 1'b0;
      cfg_q.flip_b <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        RegARows: cfg_q.a_rows <= pwdata[DimW-1:0];
        RegACols: cfg_q.a_cols <= pwdata[DimW-1:0];
        RegBRows: cfg_q.b_rows <= pwdata[DimW-1:0];
        RegBCols: cfg_q.b_cols <= pwdata[DimW-1:0];
        RegFlipA: cfg_q.flip_a <= pwdata[0];
        RegFlipB: cfg_q.flip_b <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      RegARows: prdata = 32'(cfg_q.a_rows);
      RegACols: prdata = 32'(cfg_q.a_cols);
      RegBRows: prdata = 32'(cfg_q.b_rows);
      RegBCols: prdata = 32'(cfg_q.b_cols);
      RegFlipA: prdata = 32'(cfg_q.flip_a);
      RegFlipB: prdata = 32'(cfg_q.flip_b);
      default:  prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

  // Every stored dimension has to lie in one to eight, and the inner sizes must agree.
  assign dims_ok = (cfg_q.a_rows != '0) && (cfg_q.a_rows <= DimW'(MaxDim)) &&
                   (cfg_q.a_cols != '0) && (cfg_q.a_cols <= DimW'(MaxDim)) &&
                   (cfg_q.b_rows != '0) && (cfg_q.b_rows <= DimW'(MaxDim)) &&
                   (cfg_q.b_cols != '0) && (cfg_q.b_cols <= DimW'(MaxDim));
  assign inner_b = cfg_q.flip_b ? cfg_q.b_cols : cfg_q.b_rows;

  always_comb begin
    job_d.index         = in_word_i.index;
    job_d.element       = in_word_i.element;
    job_d.geom.out_rows = cfg_q.flip_a ? cfg_q.a_cols : cfg_q.a_rows;
    job_d.geom.inner    = cfg_q.flip_a ? cfg_q.a_rows : cfg_q.a_cols;
    job_d.geom.out_cols = cfg_q.flip_b ? cfg_q.b_rows : cfg_q.b_cols;
    job_d.geom.a_cols   = cfg_q.a_cols;
    job_d.geom.b_cols   = cfg_q.b_cols;
    job_d.geom.flip_a   = cfg_q.flip_a;
    job_d.geom.flip_b   = cfg_q.flip_b;
    job_d.kind          = KIND_MISMATCH;
    push                = 1'b0;
    unique case (in_word_i.operation)
      OP_LOAD_A: begin
        job_d.kind = KIND_LOAD_A;
        push       = 1'b1;
      end
      OP_LOAD_B: begin
        job_d.kind = KIND_LOAD_B;
        push       = 1'b1;
      end
      OP_RUN: begin
        job_d.kind = (dims_ok && (job_d.geom.inner == inner_b)) ? KIND_RUN : KIND_MISMATCH;
        push       = 1'b1;
      end
      default: push = 1'b0;
    endcase
    push = push && start && !busy;
  end

  assign busy        = (count_q == 2'd2);
  assign job_valid_o = (count_q != 2'd0);
  assign pop         = job_pop_i && job_valid_o;
  assign job_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= job_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: design/tmm_back.sv
module tmm_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tmm_pkg::job_t      job_i,
  input  logic               job_valid_i,
  output logic               job_pop_o,
  output logic               out_valid_o,
  output tmm_pkg::out_word_t out_word_o
);
  import tmm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  state_e                  state_q, state_d;
  logic [ElemW-1:0]        a_mem_q [StoreDepth];
  logic [ElemW-1:0]        b_mem_q [StoreDepth];
  logic signed [ElemW-1:0] a_rd_q, b_rd_q;
  logic signed [MulW-1:0]  mul_q;
  logic signed [ProdW-1:0] acc_q;
  logic                    rd_v_q, mul_v_q;
  geom_t                   geom_q;
  logic [PosW-1:0]         x_q, y_q, i_q, x_d, y_d, i_d;
  logic                    out_valid_q, out_valid_d;
  out_word_t               out_word_q, out_word_d;
  logic                    take, we_a, we_b, start_run, emit;
  logic                    i_end, y_end, x_end;
  logic [AddrW:0]          a_lin, b_lin;
  logic [AddrW-1:0]        a_addr, b_addr;

  assign job_pop_o = (state_q == ST_IDLE);
  assign take      = job_pop_o && job_valid_i;
  assign we_a      = take && (job_i.kind == KIND_LOAD_A);
  assign we_b      = take && (job_i.kind == KIND_LOAD_B);
  assign start_run = take && (job_i.kind == KIND_RUN);
  assign emit      = (state_q == ST_DRAIN) && !rd_v_q && !mul_v_q;

  assign i_end = ({1'b0, i_q} + DimW'(1)) == geom_q.inner;
  assign y_end = ({1'b0, y_q} + DimW'(1)) == geom_q.out_cols;
  assign x_end = ({1'b0, x_q} + DimW'(1)) == geom_q.out_rows;

  // Row-major positions of the two operands, with the transposes folded in.
  always_comb begin
    if (geom_q.flip_a) begin
      a_lin = ({4'b0, i_q} * {3'b0, geom_q.a_cols}) + {4'b0, x_q};
    end else begin
      a_lin = ({4'b0, x_q} * {3'b0, geom_q.a_cols}) + {4'b0, i_q};
    end
    if (geom_q.flip_b) begin
      b_lin = ({4'b0, y_q} * {3'b0, geom_q.b_cols}) + {4'b0, i_q};
    end else begin
      b_lin = ({4'b0, i_q} * {3'b0, geom_q.b_cols}) + {4'b0, y_q};
    end
  end
  assign a_addr = a_lin[AddrW-1:0];
  assign b_addr = b_lin[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (we_a) begin
      a_mem_q[job_i.index] <= job_i.element;
    end
    a_rd_q <= a_mem_q[a_addr];
  end

  always_ff @(posedge clk_i) begin
    if (we_b) begin
      b_mem_q[job_i.index] <= job_i.element;
    end
    b_rd_q <= b_mem_q[b_addr];
  end

  always_ff @(posedge clk_i) begin
    mul_q <= a_rd_q * b_rd_q;
    if (start_run || emit) begin
      acc_q <= '0;
    end else if (mul_v_q) begin
      acc_q <= acc_q + ProdW'(mul_q);
    end
    if (start_run) begin
      geom_q <= job_i.geom;
    end
    out_word_q <= out_word_d;
  end

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    y_d         = y_q;
    i_d         = i_q;
    out_valid_d = 1'b0;
    out_word_d  = out_word_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_run) begin
          x_d     = '0;
          y_d     = '0;
          i_d     = '0;
          state_d = ST_ISSUE;
        end else if (take && (job_i.kind == KIND_MISMATCH)) begin
          out_valid_d        = 1'b1;
          out_word_d.product = '0;
          out_word_d.row     = '0;
          out_word_d.col     = '0;
          out_word_d.last    = 1'b1;
          out_word_d.status  = 1'b1;
        end
      end
      ST_ISSUE: begin
        if (i_end) begin
          i_d     = '0;
          state_d = ST_DRAIN;
        end else begin
          i_d = i_q + PosW'(1);
        end
      end
      ST_DRAIN: begin
        if (emit) begin
          out_valid_d        = 1'b1;
          out_word_d.product = acc_q;
          out_word_d.row     = x_q;
          out_word_d.col     = y_q;
          out_word_d.last    = x_end && y_end;
          out_word_d.status  = 1'b0;
          if (y_end) begin
            y_d = '0;
            x_d = x_q + PosW'(1);
          end else begin
            y_d = y_q + PosW'(1);
          end
          state_d = (x_end && y_end) ? ST_IDLE : ST_ISSUE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      x_q         <= '0;
      y_q         <= '0;
      i_q         <= '0;
      rd_v_q      <= 1'b0;
      mul_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      x_q         <= x_d;
      y_q         <= y_d;
      i_q         <= i_d;
      rd_v_q      <= (state_q == ST_ISSUE);
      mul_v_q     <= rd_v_q;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

FILE: design/transposable_matrix_multiply_core.sv
// With the back end idle, a word passes the queue; a load then goes to its store, a mismatch
// word is registered onto the outputs, and a run registers its first product after its terms
// are read, multiplied and summed. A load or mismatch frees the back end at once; a run, paced
// by the single multiply-accumulate path, holds it, and the two-word queue takes up to two more.
// Reset (rst_ni, asynchronous, active low) restores the default shape and empties the queue;
// the stores are not cleared. Each result word is shown for one cycle; the receiver cannot stall.
`include "assert_macros.svh"

module transposable_matrix_multiply_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  tmm_pkg::in_word_t          in_word_i,
  output logic                       out_valid_o,
  output tmm_pkg::out_word_t         out_word_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tmm_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import tmm_pkg::*;

  // Configuration as currently held by the front end.
  cfg_t            cfg;
  // Word travelling from the queue head to the execution side.
  job_t            job;
  logic            job_valid;
  logic            job_pop;
  // Expected shape of the product, used to check the final word of a run.
  logic [DimW-1:0] exp_rows, exp_cols;
  logic            mismatch_ok, good_last, corner_ok;

  // The register file never inserts wait states.
  assign pready = 1'b1;

  // The front end holds the registers, classifies each accepted word (load A, load B, product
  // run or shape mismatch) and parks it in a short queue.
  tmm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_word_i   (in_word_i),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .cfg_o       (cfg),
    .job_o       (job),
    .job_valid_o (job_valid),
    .job_pop_i   (job_pop)
  );

  // The back end owns both operand stores and walks the product one element at a time,
  // streaming one multiply per cycle into the accumulator while it issues an element's terms.
  tmm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .job_valid_i (job_valid),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

  assign exp_rows = cfg.flip_a ? cfg.a_cols : cfg.a_rows;
  assign exp_cols = cfg.flip_b ? cfg.b_rows : cfg.b_cols;

  assign mismatch_ok = out_word_o.last && (out_word_o.product == '0) &&
                       (out_word_o.row == '0) && (out_word_o.col == '0);
  assign good_last   = out_valid_o && !out_word_o.status && out_word_o.last;
  assign corner_ok   = (({1'b0, out_word_o.row} + 4'd1) == exp_rows) &&
                       (({1'b0, out_word_o.col} + 4'd1) == exp_cols);

  // A mismatch word is always a lone, empty, final word.
  `TMM_ASSERT_IMP(a_mismatch_shape, clk_i, rst_ni, out_valid_o && out_word_o.status, mismatch_ok)

  // The final word of a good run sits at the far corner of the configured product.
  `TMM_ASSERT_IMP(a_last_corner, clk_i, rst_ni, good_last, corner_ok)

  // The queue only fills by taking a word.
  `TMM_ASSERT_IMP(a_busy_rise, clk_i, rst_ni, $rose(busy), $past(start && !busy))

endmodule
